/* sv/ookd_pkg.sv */
package ookd_pkg;

    // frame length and derived counter width
    localparam int FRAME_BITS = 32;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int WIDTH_W    = 16;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 26;
    localparam int UNIT_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // reset values of the timing windows, microseconds
    localparam logic [WIDTH_W-1:0] RST_START_LOW  = 16'd180;
    localparam logic [WIDTH_W-1:0] RST_START_HIGH = 16'd450;
    localparam logic [WIDTH_W-1:0] RST_SYNC_MIN   = 16'd2250;
    localparam logic [WIDTH_W-1:0] RST_SHORT_LOW  = 16'd100;
    localparam logic [WIDTH_W-1:0] RST_SHORT_HIGH = 16'd450;
    localparam logic [WIDTH_W-1:0] RST_LONG_LOW   = 16'd950;
    localparam logic [WIDTH_W-1:0] RST_LONG_HIGH  = 16'd1300;
    localparam logic [WIDTH_W-1:0] RST_LONG_SPLIT = 16'd700;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LOW  = 3'd0,
        CFG_START_HIGH = 3'd1,
        CFG_SYNC_MIN   = 3'd2,
        CFG_SHORT_LOW  = 3'd3,
        CFG_SHORT_HIGH = 3'd4,
        CFG_LONG_LOW   = 3'd5,
        CFG_LONG_HIGH  = 3'd6,
        CFG_LONG_SPLIT = 3'd7
    } cfg_idx_t;

    // decoder phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_CELL  = 3'd2,
        PH_C1    = 3'd3,
        PH_C2    = 3'd4,
        PH_C3    = 3'd5
    } phase_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_REJECT   = 2'd2
    } status_t;

    // timing windows as seen by the decode logic
    typedef struct packed {
        logic [WIDTH_W-1:0] start_low;
        logic [WIDTH_W-1:0] start_high;
        logic [WIDTH_W-1:0] sync_min;
        logic [WIDTH_W-1:0] short_low;
        logic [WIDTH_W-1:0] short_high;
        logic [WIDTH_W-1:0] long_low;
        logic [WIDTH_W-1:0] long_high;
        logic [WIDTH_W-1:0] long_split;
    } cfg_t;

    // decoder state
    typedef struct packed {
        phase_t            phase;
        logic [WORD_W-1:0] bit_shift;
        logic [CNT_W-1:0]  bit_count;
    } dec_state_t;

    // one result item
    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] frame_word;
        logic [ADDR_W-1:0] device_address;
        logic              group_flag;
        logic              switch_on;
        logic [UNIT_W-1:0] unit_number;
    } result_t;

endpackage

/* sv/ookd_cfg_regs.sv */
module ookd_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ookd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ookd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ookd_pkg::cfg_t                   cfg
);
    import ookd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register select
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_LOW:  cfg_next.start_low  = cfg_data;
                CFG_START_HIGH: cfg_next.start_high = cfg_data;
                CFG_SYNC_MIN:   cfg_next.sync_min   = cfg_data;
                CFG_SHORT_LOW:  cfg_next.short_low  = cfg_data;
                CFG_SHORT_HIGH: cfg_next.short_high = cfg_data;
                CFG_LONG_LOW:   cfg_next.long_low   = cfg_data;
                CFG_LONG_HIGH:  cfg_next.long_high  = cfg_data;
                CFG_LONG_SPLIT: cfg_next.long_split = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank with default windows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low  <= RST_START_LOW;
            cfg_reg.start_high <= RST_START_HIGH;
            cfg_reg.sync_min   <= RST_SYNC_MIN;
            cfg_reg.short_low  <= RST_SHORT_LOW;
            cfg_reg.short_high <= RST_SHORT_HIGH;
            cfg_reg.long_low   <= RST_LONG_LOW;
            cfg_reg.long_high  <= RST_LONG_HIGH;
            cfg_reg.long_split <= RST_LONG_SPLIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/ookd_step.sv */
module ookd_step (
    input  ookd_pkg::cfg_t                  cfg,
    input  ookd_pkg::dec_state_t            cur,
    input  logic [ookd_pkg::WIDTH_W-1:0]    pulse_width,
    output ookd_pkg::dec_state_t            nxt,
    output ookd_pkg::result_t               res
);
    import ookd_pkg::*;

    localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(FRAME_BITS);

    logic              in_start;
    logic              at_sync;
    logic              in_cell;
    logic              is_long;
    logic              reject;
    logic              complete;
    logic [WORD_W-1:0] shift_new;
    logic [CNT_W-1:0]  count_new;

    // window compares
    assign in_start = (pulse_width >= cfg.start_low) && (pulse_width < cfg.start_high);
    assign at_sync  = pulse_width >= cfg.sync_min;
    assign in_cell  = ((pulse_width >= cfg.short_low) && (pulse_width < cfg.short_high)) ||
                      ((pulse_width >= cfg.long_low)  && (pulse_width < cfg.long_high));
    assign is_long  = pulse_width >= cfg.long_split;

    // bit decided by the fourth width of a cell: short gives 1
    assign shift_new = {cur.bit_shift[WORD_W-2:0], ~is_long};
    assign count_new = cur.bit_count + CNT_W'(1);

    // phase sequencing
    always_comb begin
        nxt      = cur;
        reject   = 1'b0;
        complete = 1'b0;
        case (cur.phase)
            PH_IDLE: begin
                if (in_start) nxt.phase = PH_START;
                else          reject = 1'b1;
            end
            PH_START: begin
                if (at_sync)       nxt.phase = PH_CELL;
                else if (!in_cell) reject = 1'b1;
            end
            PH_CELL: begin
                if (in_cell && !is_long) nxt.phase = PH_C1;
                else                     reject = 1'b1;
            end
            PH_C1: begin
                if (in_cell) nxt.phase = PH_C2;
                else         reject = 1'b1;
            end
            PH_C2: begin
                if (in_cell) nxt.phase = PH_C3;
                else         reject = 1'b1;
            end
            PH_C3: begin
                if (!in_cell) begin
                    reject = 1'b1;
                end else if (count_new >= FRAME_LAST) begin
                    complete = 1'b1;
                end else begin
                    nxt.phase     = PH_CELL;
                    nxt.bit_shift = shift_new;
                    nxt.bit_count = count_new;
                end
            end
            default: reject = 1'b1;
        endcase
        // error and completion both return to idle
        if (reject || complete) begin
            nxt.phase     = PH_IDLE;
            nxt.bit_shift = '0;
            nxt.bit_count = '0;
        end
    end

    // result fields: frame fields zero unless a frame completes, status marks reject or pending otherwise
    always_comb begin
        res = '0;
        if (complete) begin
            res.status         = ST_COMPLETE;
            res.frame_word     = shift_new;
            res.device_address = shift_new[WORD_W-1:WORD_W-ADDR_W];
            res.group_flag     = shift_new[5];
            res.switch_on      = shift_new[4];
            res.unit_number    = shift_new[UNIT_W-1:0];
        end else if (reject) begin
            res.status = ST_REJECT;
        end else begin
            res.status = ST_PENDING;
        end
    end

endmodule

/* sv/ook_pulse_width_frame_decoder.sv */
// a request is taken into the input register, then moves into the result register and shows on m_*
// throughput: one request per cycle while m_ready does not stall the result register
// result register stalls hold the input register, which in turn lowers s_ready
// reset: synchronous active-low aresetn clears the phase, shift and count state,
// both stage valid flags, and loads the default timing windows
module ook_pulse_width_frame_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ookd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ookd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ookd_pkg::WIDTH_W-1:0]     s_pulse_width,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [ookd_pkg::WORD_W-1:0]      m_frame_word,
    output logic [ookd_pkg::ADDR_W-1:0]      m_device_address,
    output logic                             m_group_flag,
    output logic                             m_switch_on,
    output logic [ookd_pkg::UNIT_W-1:0]      m_unit_number
);
    import ookd_pkg::*;

    cfg_t               cfg;
    dec_state_t         state_reg;
    dec_state_t         state_next;
    result_t            res_next;
    result_t            res_reg;
    logic               in_vld_reg;
    logic [WIDTH_W-1:0] in_width_reg;
    logic               out_vld_reg;
    logic               out_free;
    logic               fire;

    // configuration bank
    ookd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // decode of one width against current state
    ookd_step u_step (
        .cfg         (cfg),
        .cur         (state_reg),
        .pulse_width (in_width_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    // stage handshakes
    assign out_free = !out_vld_reg || m_ready;
    assign fire     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_width_reg <= s_pulse_width;
        end
    end

    // decoder state, advanced once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= PH_IDLE;
            state_reg.bit_shift <= '0;
            state_reg.bit_count <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_status         = res_reg.status;
    assign m_frame_word     = res_reg.frame_word;
    assign m_device_address = res_reg.device_address;
    assign m_group_flag     = res_reg.group_flag;
    assign m_switch_on      = res_reg.switch_on;
    assign m_unit_number    = res_reg.unit_number;

    // idle always carries an empty shift register and count
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_IDLE |-> (state_reg.bit_shift == '0 && state_reg.bit_count == '0))
        else $error("idle phase with stale shift state");

    // the bit count never reaches the frame length while a frame is open
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bit_count < CNT_W'(FRAME_BITS))
        else $error("bit count out of range");

    // a rejected request leaves the decoder idle
    a_reject_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_next.status == ST_REJECT |=> state_reg.phase == PH_IDLE)
        else $error("reject did not return to idle");

    // only a completed frame carries a non-zero word
    a_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_COMPLETE |-> (m_frame_word == '0 && m_unit_number == '0))
        else $error("frame fields set without completion");

    // unpacked address agrees with the frame word
    a_addr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_device_address == m_frame_word[WORD_W-1:WORD_W-ADDR_W])
        else $error("device address mismatch");

endmodule
